[src/arau_pkg.sv]
package arau_pkg;

  localparam int ADDR_W      = 48;
  localparam int MAX_REGIONS = 64;
  localparam int PAGE_BYTES  = 4096;
  localparam int IDX_W       = $clog2(MAX_REGIONS);
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
  localparam int SUM_W       = ADDR_W + 2;

  localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_REGIONS);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FIXED = 2'd1,
    OP_FREE  = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_BAD_SIZE   = 3'd1,
    STS_NO_SPACE   = 3'd2,
    STS_NOT_FOUND  = 3'd3,
    STS_TABLE_FULL = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_DONE
  } seq_state_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
  } region_t;

  typedef struct packed {
    logic [ADDR_W:0] end_addr;
    logic            above_top;
    logic            match;
    logic            clash;
    logic            hit;
    logic            empty;
  } cmp_res_t;

endpackage

[src/arau_table.sv]
module arau_table (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [arau_pkg::IDX_W-1:0]       rd_idx,
  output arau_pkg::region_t                rd_entry,
  input  logic                             wr_en,
  input  logic [arau_pkg::IDX_W-1:0]       wr_idx,
  input  logic [arau_pkg::ADDR_W-1:0]      wr_base,
  input  logic [arau_pkg::ADDR_W-1:0]      wr_size,
  input  logic                             clr_en,
  input  logic [arau_pkg::IDX_W-1:0]       clr_idx
);
  import arau_pkg::*;

  logic [ADDR_W-1:0]      base_mem [MAX_REGIONS];
  logic [ADDR_W-1:0]      size_mem [MAX_REGIONS];
  logic [MAX_REGIONS-1:0] valid;
  logic [ADDR_W-1:0]      rd_base;
  logic [ADDR_W-1:0]      rd_size;
  logic                   rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      base_mem[wr_idx] <= wr_base;
      size_mem[wr_idx] <= wr_size;
    end
    rd_base <= base_mem[rd_idx];
    rd_size <= size_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_idx] <= 1'b1;
      end
      if (clr_en) begin
        valid[clr_idx] <= 1'b0;
      end
      rd_valid <= valid[rd_idx];
    end
  end

  assign rd_entry = '{valid: rd_valid, base: rd_base, size: rd_size};

endmodule

[src/arau_cmp.sv]
module arau_cmp (
  input  arau_pkg::region_t           entry,
  input  logic [arau_pkg::ADDR_W-1:0] addr,
  input  logic [arau_pkg::ADDR_W-1:0] len,
  input  logic [arau_pkg::ADDR_W:0]   addr_end,
  input  logic [arau_pkg::ADDR_W:0]   top,
  output arau_pkg::cmp_res_t          res
);
  import arau_pkg::*;

  logic [ADDR_W:0] ent_end;

  assign ent_end = {1'b0, entry.base} + {1'b0, entry.size};

  // half-open ranges throughout: [base, base + size)
  always_comb begin
    res.end_addr  = ent_end;
    res.above_top = entry.valid && (ent_end > top);
    res.match     = entry.valid && (entry.base == addr) && (entry.size == len);
    res.clash     = entry.valid && ({1'b0, addr} < ent_end) &&
                    ({1'b0, entry.base} < addr_end);
    res.hit       = entry.valid && (addr >= entry.base) && ({1'b0, addr} < ent_end);
    res.empty     = !entry.valid;
  end

endmodule

[src/address_region_allocator_unit.sv]
// address region allocator
// input channel: in_valid / in_stall with op, address and length; output
// channel: out_valid / out_stall with status, result_address and hit. the
// limit for bump allocations is written through cfg_write / cfg_data; the
// user must do so only while the block is idle, which the block itself does
// not enforce. the limit resets to the top of the 48-bit space. every word
// in gives exactly one word out. a word is taken only while the block is
// idle; it then sweeps the whole region table through its single read port,
// one entry a cycle, and then decides and writes back. only after that
// write-back does the block return to idle and take a new word, so it never
// works on two words at once.
// the result sits in an output register: if the receiver stalls, the
// finished word holds there and the block waits with its write-back until
// that register can be loaded, so no word is lost or repeated.
// reset empties the table (valid bits and count cleared at once, no sweep)
// and restores the limit; entry contents are not cleared.
module address_region_allocator_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [arau_pkg::ADDR_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  op,
  input  logic [arau_pkg::ADDR_W-1:0] address,
  input  logic [arau_pkg::ADDR_W-1:0] length,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  status,
  output logic [arau_pkg::ADDR_W-1:0] result_address,
  output logic                        hit
);
  import arau_pkg::*;

  seq_state_t        state;
  seq_state_t        state_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_prev;
  logic [IDX_W-1:0]  eval_idx;

  op_t               cur_op;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] cur_len;
  logic [ADDR_W:0]   cur_end;
  logic [ADDR_W-1:0] highest;
  logic [CNT_W-1:0]  region_count;

  logic [ADDR_W:0]   top_acc;
  logic              clash_acc;
  logic              hit_acc;
  logic              found;
  logic [IDX_W-1:0]  found_idx;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;

  logic              load;
  logic              scan_eval;
  logic              out_free;
  logic              finish;

  region_t           entry;
  cmp_res_t          res;

  status_t           fin_status;
  logic [ADDR_W-1:0] fin_result;
  logic              fin_hit;
  logic              do_insert;
  logic              do_clear;
  logic [ADDR_W-1:0] ins_base;
  logic              bad_len;
  logic              tbl_full;
  logic [SUM_W-1:0]  bump_end;
  logic [SUM_W-1:0]  bump_lim;
  logic              bump_over;
  logic              fixed_over;

  logic              tbl_wr_en;
  logic              tbl_clr_en;

  arau_table u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (cnt[IDX_W-1:0]),
    .rd_entry (entry),
    .wr_en    (tbl_wr_en),
    .wr_idx   (free_idx),
    .wr_base  (ins_base),
    .wr_size  (cur_len),
    .clr_en   (tbl_clr_en),
    .clr_idx  (found_idx)
  );

  arau_cmp u_cmp (
    .entry    (entry),
    .addr     (cur_addr),
    .len      (cur_len),
    .addr_end (cur_end),
    .top      (top_acc),
    .res      (res)
  );

  assign cnt_prev = cnt - CNT_W'(1);
  assign eval_idx = cnt_prev[IDX_W-1:0];
  assign out_free = !out_valid || !out_stall;

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: if (in_valid)         state_next = SEQ_SCAN;
      SEQ_SCAN: if (cnt == CNT_MAX)   state_next = SEQ_DONE;
      SEQ_DONE: if (out_free)         state_next = SEQ_IDLE;
      default:                        state_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != SEQ_IDLE);
    load      = (state == SEQ_IDLE) && in_valid;
    scan_eval = (state == SEQ_SCAN) && (cnt != '0);
    finish    = (state == SEQ_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      highest <= '1;
    end else if (cfg_write) begin
      highest <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_op   <= op_t'(op);
      cur_addr <= address;
      cur_len  <= length;
      cur_end  <= {1'b0, address} + {1'b0, length};
    end
  end

  // scan accumulators, entry k is seen when cnt is k + 1
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      top_acc    <= '0;
      clash_acc  <= 1'b0;
      hit_acc    <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (load) begin
      cnt        <= '0;
      top_acc    <= '0;
      clash_acc  <= 1'b0;
      hit_acc    <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (state == SEQ_SCAN) begin
      cnt <= cnt + CNT_W'(1);
      if (scan_eval) begin
        if (res.above_top) begin
          top_acc <= res.end_addr;
        end
        clash_acc <= clash_acc | res.clash;
        hit_acc   <= hit_acc | res.hit;
        if (!found && res.match) begin
          found <= 1'b1;
        end
        if (!free_found && res.empty) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_eval && !found && res.match) begin
      found_idx <= eval_idx;
    end
    if (scan_eval && !free_found && res.empty) begin
      free_idx <= eval_idx;
    end
  end

  // decision at the end of the sweep
  always_comb begin
    bad_len    = (cur_len == '0) || ((cur_len & PAGE_MASK) != '0);
    tbl_full   = (region_count == CNT_MAX);
    bump_end   = SUM_W'(top_acc) + SUM_W'(cur_len);
    bump_lim   = SUM_W'(highest) + SUM_W'(1);
    bump_over  = bump_end > bump_lim;
    // last byte beyond the 48-bit space
    fixed_over = cur_end[ADDR_W] && (cur_end[ADDR_W-1:0] != '0);

    fin_status = STS_OK;
    fin_result = '0;
    fin_hit    = 1'b0;
    do_insert  = 1'b0;
    do_clear   = 1'b0;
    ins_base   = cur_addr;
    unique case (cur_op)
      OP_ALLOC: begin
        ins_base = top_acc[ADDR_W-1:0];
        priority if (bad_len) begin
          fin_status = STS_BAD_SIZE;
        end else if (tbl_full) begin
          fin_status = STS_TABLE_FULL;
        end else if (bump_over) begin
          fin_status = STS_NO_SPACE;
        end else begin
          do_insert  = 1'b1;
          fin_result = top_acc[ADDR_W-1:0];
        end
      end
      OP_FIXED: begin
        priority if (bad_len || ((cur_addr & PAGE_MASK) != '0)) begin
          fin_status = STS_BAD_SIZE;
        end else if (tbl_full) begin
          fin_status = STS_TABLE_FULL;
        end else if (fixed_over || clash_acc) begin
          fin_status = STS_NO_SPACE;
        end else begin
          do_insert = 1'b1;
        end
      end
      OP_FREE: begin
        // an empty table reports ok
        if (region_count != '0) begin
          if (found) begin
            do_clear = 1'b1;
          end else begin
            fin_status = STS_NOT_FOUND;
          end
        end
      end
      OP_QUERY: begin
        fin_hit = hit_acc;
      end
      default: begin
        fin_status = STS_OK;
      end
    endcase
  end

  assign tbl_wr_en  = finish && do_insert;
  assign tbl_clr_en = finish && do_clear;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_count <= '0;
    end else if (tbl_wr_en) begin
      region_count <= region_count + CNT_W'(1);
    end else if (tbl_clr_en) begin
      region_count <= region_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status         <= fin_status;
      result_address <= fin_result;
      hit            <= fin_hit;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    region_count <= CNT_MAX)
    else $error("region count beyond table depth");

  a_out_from_done : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == SEQ_DONE))
    else $error("result word raised outside write-back");

  a_accept_starts_scan : assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == SEQ_SCAN) && (cnt == '0))
    else $error("accepted word did not start a sweep");

  a_wr_clr_excl : assert property (@(posedge clk) disable iff (rst)
    !(tbl_wr_en && tbl_clr_en))
    else $error("insert and free in the same cycle");

endmodule

[verif/tb_address_region_allocator_unit.sv]
`timescale 1ns / 100ps

module tb_address_region_allocator_unit;
  import arau_pkg::*;

  localparam logic [ADDR_W-1:0] PAGE     = ADDR_W'(PAGE_BYTES);
  localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};
  localparam logic [ADDR_W-1:0] TOP_PAGE = ALL_ONES & ~PAGE_MASK;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_WORDS    = 325;
  localparam int LONG_HOLD      = 500;

  typedef struct packed {
    status_t           st;
    logic [ADDR_W-1:0] addr;
    logic              hit;
  } outcome_t;

  typedef struct {
    op_t               code;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] len;
    bit                typed;
    outcome_t          out;
  } step_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [ADDR_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        op = '0;
  logic [ADDR_W-1:0] address = '0;
  logic [ADDR_W-1:0] length = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        status;
  logic [ADDR_W-1:0] result_address;
  logic              hit;

  // shadow of the region table
  logic [ADDR_W-1:0] tbl_base [MAX_REGIONS];
  logic [ADDR_W-1:0] tbl_size [MAX_REGIONS];
  bit                tbl_used [MAX_REGIONS];
  int                tbl_count = 0;
  logic [ADDR_W-1:0] bump_limit = ALL_ONES;

  outcome_t pending [$];
  int       fail_count = 0;
  int       results_seen = 0;
  int       tx_idle_pct = 23;
  int       rx_idle_pct = 64;
  bit       start_hold = 1'b0;
  int       hold_left = 0;
  int       quiet_cycles = 0;
  bit       filling = 1'b1;

  step_row_t steps [25] = '{
    '{OP_FREE,  48'h0,              48'h0,         1'b1, '{STS_OK, 48'h0, 1'b0}},
    '{OP_QUERY, 48'h0,              48'h0,         1'b1, '{STS_OK, 48'h0, 1'b0}},
    '{OP_ALLOC, 48'h0,              48'h0,         1'b1, '{STS_BAD_SIZE, 48'h0, 1'b0}},
    '{OP_ALLOC, ALL_ONES,           48'h800,       1'b1, '{STS_BAD_SIZE, 48'h0, 1'b0}},
    '{OP_ALLOC, 48'h0,              ALL_ONES,      1'b1, '{STS_BAD_SIZE, 48'h0, 1'b0}},
    '{OP_ALLOC, 48'h0,              48'h1000,      1'b1, '{STS_OK, 48'h0, 1'b0}},
    '{OP_ALLOC, ALL_ONES,           48'h3000,      1'b1, '{STS_OK, 48'h1000, 1'b0}},
    '{OP_FIXED, 48'h123,            48'h1000,      1'b1, '{STS_BAD_SIZE, 48'h0, 1'b0}},
    '{OP_FIXED, 48'h2000,           48'h1000,      1'b1, '{STS_NO_SPACE, 48'h0, 1'b0}},
    '{OP_FIXED, TOP_PAGE,           48'h1000,      1'b1, '{STS_OK, 48'h0, 1'b0}},
    '{OP_FIXED, 48'hFFFF_FFFF_E000, 48'h3000,      1'b1, '{STS_NO_SPACE, 48'h0, 1'b0}},
    '{OP_QUERY, ALL_ONES,           ALL_ONES,      1'b1, '{STS_OK, 48'h0, 1'b1}},
    '{OP_QUERY, 48'h4000,           48'h0,         1'b1, '{STS_OK, 48'h0, 1'b0}},
    '{OP_QUERY, 48'h3FFF,           48'h0,         1'b1, '{STS_OK, 48'h0, 1'b1}},
    '{OP_ALLOC, 48'h0,              48'h1000,      1'b1, '{STS_NO_SPACE, 48'h0, 1'b0}},
    '{OP_FREE,  48'h1000,           48'h2000,      1'b1, '{STS_NOT_FOUND, 48'h0, 1'b0}},
    '{OP_FREE,  48'h1000,           48'h3000,      1'b1, '{STS_OK, 48'h0, 1'b0}},
    '{OP_QUERY, 48'h1000,           48'h0,         1'b1, '{STS_OK, 48'h0, 1'b0}},
    '{OP_FIXED, 48'h1000,           48'h3000,      1'b1, '{STS_OK, 48'h0, 1'b0}},
    '{OP_FIXED, 48'h0,              TOP_PAGE,      1'b1, '{STS_NO_SPACE, 48'h0, 1'b0}},
    '{OP_FREE,  TOP_PAGE,           48'h1000,      1'b1, '{STS_OK, 48'h0, 1'b0}},
    '{OP_FREE,  TOP_PAGE,           48'h1000,      1'b1, '{STS_NOT_FOUND, 48'h0, 1'b0}},
    '{OP_ALLOC, 48'h0,              48'h1000,      1'b1, '{STS_OK, 48'h4000, 1'b0}},
    '{OP_ALLOC, 48'h0,              TOP_PAGE,      1'b1, '{STS_NO_SPACE, 48'h0, 1'b0}},
    '{OP_FIXED, 48'h5000,           48'h7_0000,    1'b0, '{STS_OK, 48'h0, 1'b0}}
  };

  address_region_allocator_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .address        (address),
    .length         (length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .result_address (result_address),
    .hit            (hit)
  );

  always #6 clk = ~clk;

  initial begin
    for (int i = 0; i < MAX_REGIONS; i++) begin
      tbl_base[i] = '0;
      tbl_size[i] = '0;
      tbl_used[i] = 1'b0;
    end
  end

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic bit bad_length(input logic [ADDR_W-1:0] l);
    return (l == '0) || ((l % PAGE) != '0);
  endfunction

  function automatic int lowest_free_slot();
    for (int i = 0; i < MAX_REGIONS; i++) begin
      if (!tbl_used[i]) return i;
    end
    return -1;
  endfunction

  // applies one word to the shadow table and gives the result it must produce
  task automatic apply_region_op(input op_t o, input logic [ADDR_W-1:0] a,
                                 input logic [ADDR_W-1:0] l, output outcome_t res);
    int slot;
    logic [ADDR_W+1:0] top;
    logic [ADDR_W+1:0] span_end;
    bit clash;
    res = '{STS_OK, '0, 1'b0};
    case (o)
      OP_ALLOC: begin
        slot = lowest_free_slot();
        if (bad_length(l)) begin
          res.st = STS_BAD_SIZE;
        end else if (slot < 0) begin
          res.st = STS_TABLE_FULL;
        end else begin
          top = '0;
          for (int i = 0; i < MAX_REGIONS; i++) begin
            if (tbl_used[i] && ({2'b00, tbl_base[i]} + {2'b00, tbl_size[i]}) > top)
              top = {2'b00, tbl_base[i]} + {2'b00, tbl_size[i]};
          end
          if (top + {2'b00, l} - 1 > {2'b00, bump_limit}) begin
            res.st = STS_NO_SPACE;
          end else begin
            tbl_base[slot] = top[ADDR_W-1:0];
            tbl_size[slot] = l;
            tbl_used[slot] = 1'b1;
            tbl_count++;
            res.addr = top[ADDR_W-1:0];
          end
        end
      end
      OP_FIXED: begin
        slot = lowest_free_slot();
        span_end = {2'b00, a} + {2'b00, l};
        if (bad_length(l) || (a % PAGE) != '0) begin
          res.st = STS_BAD_SIZE;
        end else if (slot < 0) begin
          res.st = STS_TABLE_FULL;
        end else if (span_end - 1 > {2'b00, ALL_ONES}) begin
          res.st = STS_NO_SPACE;
        end else begin
          clash = 1'b0;
          for (int i = 0; i < MAX_REGIONS; i++) begin
            if (tbl_used[i] && {2'b00, a} < {2'b00, tbl_base[i]} + {2'b00, tbl_size[i]}
                && {2'b00, tbl_base[i]} < span_end)
              clash = 1'b1;
          end
          if (clash) begin
            res.st = STS_NO_SPACE;
          end else begin
            tbl_base[slot] = a;
            tbl_size[slot] = l;
            tbl_used[slot] = 1'b1;
            tbl_count++;
          end
        end
      end
      OP_FREE: begin
        if (tbl_count != 0) begin
          res.st = STS_NOT_FOUND;
          for (int i = 0; i < MAX_REGIONS; i++) begin
            if (res.st == STS_NOT_FOUND && tbl_used[i] && tbl_base[i] == a
                && tbl_size[i] == l) begin
              tbl_used[i] = 1'b0;
              tbl_count--;
              res.st = STS_OK;
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < MAX_REGIONS; i++) begin
          if (tbl_used[i] && a >= tbl_base[i]
              && {2'b00, a} < {2'b00, tbl_base[i]} + {2'b00, tbl_size[i]})
            res.hit = 1'b1;
        end
      end
    endcase
  endtask

  function automatic logic [ADDR_W-1:0] rand_wide();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  function automatic int some_region();
    int start;
    start = $urandom_range(MAX_REGIONS - 1);
    for (int k = 0; k < MAX_REGIONS; k++) begin
      if (tbl_used[(start + k) % MAX_REGIONS]) return (start + k) % MAX_REGIONS;
    end
    return -1;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    int roll;
    int idx;
    roll = $urandom_range(99);
    idx = some_region();
    if (roll < 40 && idx >= 0) begin
      case ($urandom_range(2))
        0: return tbl_base[idx];
        1: return tbl_base[idx] + tbl_size[idx];
        default: return tbl_base[idx] - ADDR_W'($urandom_range(1, 4)) * PAGE;
      endcase
    end
    if (roll < 75) return ADDR_W'($urandom_range(511)) * PAGE;
    // just below the top of the address space
    if (roll < 85) return '0 - ADDR_W'($urandom_range(1, 16)) * PAGE;
    if (roll < 90)
      return ADDR_W'($urandom_range(511)) * PAGE + ADDR_W'($urandom_range(1, PAGE_BYTES - 1));
    return rand_wide();
  endfunction

  function automatic logic [ADDR_W-1:0] pick_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 85) return ADDR_W'($urandom_range(1, 16)) * PAGE;
    if (roll < 90) return '0;
    if (roll < 95) return rand_wide();
    return rand_wide() & ~PAGE_MASK;
  endfunction

  task automatic random_word(output op_t o, output logic [ADDR_W-1:0] a,
                             output logic [ADDR_W-1:0] l);
    int roll;
    int idx;
    logic [63:0] wide;
    roll = $urandom_range(99);
    if (roll < 10) begin
      o = op_t'($urandom_range(3));
      a = rand_wide();
      l = rand_wide();
      return;
    end
    roll = $urandom_range(99);
    if (filling)
      o = (roll < 45) ? OP_ALLOC : (roll < 70) ? OP_FIXED : (roll < 80) ? OP_FREE : OP_QUERY;
    else
      o = (roll < 10) ? OP_ALLOC : (roll < 20) ? OP_FIXED : (roll < 80) ? OP_FREE : OP_QUERY;
    a = pick_address();
    l = pick_length();
    idx = some_region();
    if (o == OP_FREE && idx >= 0) begin
      roll = $urandom_range(99);
      if (roll < 75) begin
        a = tbl_base[idx];
        l = tbl_size[idx];
      end else if (roll < 85) begin
        a = tbl_base[idx];
        l = tbl_size[idx] + PAGE;
      end
    end else if (o == OP_QUERY && idx >= 0 && $urandom_range(1) == 1) begin
      // anywhere in the region, its end included
      wide = {$urandom, $urandom};
      a = tbl_base[idx] + ADDR_W'(wide % ({16'h0, tbl_size[idx]} + 64'd1));
    end
  endtask

  task automatic send_word(input op_t o, input logic [ADDR_W-1:0] a,
                           input logic [ADDR_W-1:0] l, input bit typed,
                           input outcome_t given);
    outcome_t model;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    address  <= a;
    length   <= l;
    do @(posedge clk); while (in_stall);
    apply_region_op(o, a, l, model);
    pending.push_back(typed ? given : model);
  endtask

  task automatic drain_and_set_limit(input logic [ADDR_W-1:0] value);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    bump_limit = value;
  endtask

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (start_hold) begin
      hold_left = LONG_HOLD;
      start_hold = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending.size() == 0) begin
        flag_mismatch($sformatf("word %0d arrived with nothing expected", results_seen));
      end else begin
        want = pending.pop_front();
        if (status !== want.st)
          flag_mismatch($sformatf("word %0d status %0d, wanted %0d",
                                  results_seen, status, want.st));
        if (result_address !== want.addr)
          flag_mismatch($sformatf("word %0d result_address %h, wanted %h",
                                  results_seen, result_address, want.addr));
        if (hit !== want.hit)
          flag_mismatch($sformatf("word %0d hit %b, wanted %b",
                                  results_seen, hit, want.hit));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles", $realtime, quiet_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [ADDR_W-1:0] limits [6];
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] l;
    op_t o;
    int flip_left;
    limits = '{ALL_ONES, 48'h3F_FFFF, 48'h0, 48'hFFF, 48'h0, ALL_ONES};
    limits[4] = rand_wide();
    flip_left = 80;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (steps[i]) begin
      send_word(steps[i].code, steps[i].addr, steps[i].len, steps[i].typed, steps[i].out);
    end

    for (int p = 0; p < 6; p++) begin
      drain_and_set_limit(limits[p]);
      tx_idle_pct = (p < 2) ? 23 : (p < 4) ? 64 : 0;
      rx_idle_pct = (p < 2) ? 64 : (p < 4) ? 23 : 0;
      // hold the receiver off so the block backs up into its input
      if (p == 0) start_hold = 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        flip_left = flip_left - 1;
        if (flip_left == 0) begin
          filling = !filling;
          flip_left = $urandom_range(60, 140);
        end
        random_word(o, a, l);
        send_word(o, a, l, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (pending.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending.size()));
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
src/arau_pkg.sv
src/arau_table.sv
src/arau_cmp.sv
src/address_region_allocator_unit.sv
verif/tb_address_region_allocator_unit.sv
